[rtl/hpq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the max-heap priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package hpq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int OCC_W        = 7;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 48;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_PEEK   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_LD,
        S_DN_RD,
        S_DN_CMP,
        S_PEEK_LD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_ins;
        logic res_full;
        logic res_empty;
        logic rd_up;
        logic up_move;
        logic put_key;
        logic inc_count;
        logic rd_del;
        logic del_load;
        logic rd_dn;
        logic dn_move;
        logic rd_root;
        logic peek_load;
        logic clear_count;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic pos_root;
        logic child_in;
        logic up_gt;
        logic dn_gt;
    } t_dp_status;

endpackage

[rtl/hpq_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the max-heap priority queue: request decode, sift sequencing
// and the output word handshake. Depends on hpq_pkg.
module hpq_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  hpq_pkg::t_mode             i_mode,
    output logic                       o_in_ready,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    input  hpq_pkg::t_dp_status        i_st,
    output hpq_pkg::t_dp_cmd           o_cmd
);

    hpq_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            hpq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_mode)
                        hpq_pkg::MODE_INSERT: begin
                            if (i_st.full) begin
                                o_cmd.res_full = 1'b1;
                                n_state        = hpq_pkg::S_DONE;
                            end else begin
                                o_cmd.start_ins = 1'b1;
                                n_state         = hpq_pkg::S_UP_RD;
                            end
                        end
                        hpq_pkg::MODE_DELETE: begin
                            if (i_st.empty) begin
                                o_cmd.res_empty = 1'b1;
                                n_state         = hpq_pkg::S_DONE;
                            end else begin
                                o_cmd.rd_del = 1'b1;
                                n_state      = hpq_pkg::S_DEL_LD;
                            end
                        end
                        hpq_pkg::MODE_PEEK: begin
                            if (i_st.empty) begin
                                o_cmd.res_empty = 1'b1;
                                n_state         = hpq_pkg::S_DONE;
                            end else begin
                                o_cmd.rd_root = 1'b1;
                                n_state       = hpq_pkg::S_PEEK_LD;
                            end
                        end
                        hpq_pkg::MODE_CLEAR: begin
                            o_cmd.clear_count = 1'b1;
                            n_state           = hpq_pkg::S_DONE;
                        end
                        default: n_state = hpq_pkg::S_DONE;
                    endcase
                end
            end
            hpq_pkg::S_UP_RD: begin
                if (i_st.pos_root) begin
                    o_cmd.put_key   = 1'b1;
                    o_cmd.inc_count = 1'b1;
                    n_state         = hpq_pkg::S_DONE;
                end else begin
                    o_cmd.rd_up = 1'b1;
                    n_state     = hpq_pkg::S_UP_CMP;
                end
            end
            hpq_pkg::S_UP_CMP: begin
                if (i_st.up_gt) begin
                    o_cmd.up_move = 1'b1;
                    n_state       = hpq_pkg::S_UP_RD;
                end else begin
                    o_cmd.put_key   = 1'b1;
                    o_cmd.inc_count = 1'b1;
                    n_state         = hpq_pkg::S_DONE;
                end
            end
            hpq_pkg::S_DEL_LD: begin
                o_cmd.del_load = 1'b1;
                n_state        = hpq_pkg::S_DN_RD;
            end
            hpq_pkg::S_DN_RD: begin
                if (i_st.child_in) begin
                    o_cmd.rd_dn = 1'b1;
                    n_state     = hpq_pkg::S_DN_CMP;
                end else begin
                    o_cmd.put_key = 1'b1;
                    n_state       = hpq_pkg::S_DONE;
                end
            end
            hpq_pkg::S_DN_CMP: begin
                if (i_st.dn_gt) begin
                    o_cmd.dn_move = 1'b1;
                    n_state       = hpq_pkg::S_DN_RD;
                end else begin
                    o_cmd.put_key = 1'b1;
                    n_state       = hpq_pkg::S_DONE;
                end
            end
            hpq_pkg::S_PEEK_LD: begin
                o_cmd.peek_load = 1'b1;
                n_state         = hpq_pkg::S_DONE;
            end
            hpq_pkg::S_DONE: begin
                // The result waits here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = hpq_pkg::S_IDLE;
                end
            end
            default: n_state = hpq_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[rtl/hpq_dp.sv]
`timescale 1ns / 1ps
// Datapath of the max-heap priority queue: heap memory with two read ports,
// sift position, moving key, element count and the output word register. Depends on hpq_pkg.
module hpq_dp #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hpq_pkg::t_dp_cmd                    i_cmd,
    input  logic signed [hpq_pkg::KEY_W-1:0]    i_key,
    output hpq_pkg::t_dp_status                 o_st,
    output logic [hpq_pkg::M_TDATA_W-1:0]       o_out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 1;

    logic signed [hpq_pkg::KEY_W-1:0] r_mem [CAPACITY];
    logic signed [hpq_pkg::KEY_W-1:0] r_rd_a, r_rd_b;
    logic signed [hpq_pkg::KEY_W-1:0] r_key, r_value;
    logic [AW-1:0]                    r_pos;
    logic [CW-1:0]                    r_count;
    hpq_pkg::t_status                 r_status;
    logic [hpq_pkg::M_TDATA_W-1:0]    r_out_data;

    logic [AW-1:0]                    addr_a, addr_b, waddr, parent, best_idx;
    logic [XW-1:0]                    left_x, right_x, count_x;
    logic                             right_in, left_gt, right_gt, we;
    logic signed [hpq_pkg::KEY_W-1:0] wdata, left_best;

    assign parent   = (r_pos - AW'(1)) >> 1;
    assign left_x   = {r_pos, 1'b1};
    assign right_x  = left_x + XW'(1);
    assign count_x  = XW'(r_count);
    assign right_in = right_x < count_x;

    // Left wins a tie with the right child; a child moves only when strictly greater.
    assign left_gt   = r_rd_a > r_key;
    assign left_best = left_gt ? r_rd_a : r_key;
    assign right_gt  = right_in && (r_rd_b > left_best);
    assign best_idx  = right_gt ? right_x[AW-1:0] : left_x[AW-1:0];

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        if (i_cmd.rd_up) begin
            addr_a = parent;
        end else if (i_cmd.rd_dn) begin
            addr_a = left_x[AW-1:0];
            addr_b = right_in ? right_x[AW-1:0] : '0;
        end else if (i_cmd.rd_del) begin
            addr_b = AW'(r_count - CW'(1));
        end
    end

    always_comb begin
        we    = i_cmd.put_key | i_cmd.up_move | i_cmd.dn_move;
        waddr = r_pos;
        if (i_cmd.put_key) begin
            wdata = r_key;
        end else if (i_cmd.up_move) begin
            wdata = r_rd_a;
        end else begin
            wdata = right_gt ? r_rd_b : r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear_count) begin
            r_count <= '0;
        end else if (i_cmd.inc_count) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.del_load) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_ins) begin
            r_key <= i_key;
            r_pos <= AW'(r_count);
        end else if (i_cmd.del_load) begin
            r_key <= r_rd_b;
            r_pos <= '0;
        end else if (i_cmd.up_move) begin
            r_pos <= parent;
        end else if (i_cmd.dn_move) begin
            r_pos <= best_idx;
        end

        if (i_cmd.res_empty) begin
            r_value  <= '1;
            r_status <= hpq_pkg::STATUS_EMPTY;
        end else if (i_cmd.res_full) begin
            r_value  <= '0;
            r_status <= hpq_pkg::STATUS_FULL;
        end else if (i_cmd.accept) begin
            r_value  <= '0;
            r_status <= hpq_pkg::STATUS_OK;
        end else if (i_cmd.del_load || i_cmd.peek_load) begin
            r_value <= r_rd_a;
        end

        if (i_cmd.out_load) begin
            r_out_data <= {
                {(hpq_pkg::M_TDATA_W - hpq_pkg::KEY_W - hpq_pkg::STATUS_W
                  - hpq_pkg::OCC_W){1'b0}},
                hpq_pkg::OCC_W'(r_count),
                r_status,
                r_value
            };
        end
    end

    assign o_st.full     = r_count >= CW'(CAPACITY);
    assign o_st.empty    = r_count == '0;
    assign o_st.pos_root = r_pos == '0;
    assign o_st.child_in = left_x < count_x;
    assign o_st.up_gt    = r_key > r_rd_a;
    assign o_st.dn_gt    = left_gt | right_gt;
    assign o_out_data    = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count beyond capacity");
    a_no_full_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inc_count |-> !o_st.full)
        else $error("insert completed on a full heap");
    a_up_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.up_move |-> !o_st.pos_root)
        else $error("sift-up moved past the root");
    a_dn_child: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.dn_move |-> o_st.child_in)
        else $error("sift-down moved to a child outside the heap");
    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.del_load |=> r_count == $past(r_count) - CW'(1))
        else $error("delete did not shrink the heap by one");
`endif

endmodule

[rtl/max_heap_priority_queue.sv]
`timescale 1ns / 1ps
// Max-heap priority queue: input word in, one result word out per request.
// Depends on hpq_pkg, hpq_ctrl and hpq_dp.
//
// Input channel s_axis: tdata[1:0] mode (insert, delete max, peek max, clear),
// tdata[33:2] signed key. Output channel m_axis: tdata[31:0] value,
// [33:32] status (ok, full, empty), [40:34] occupancy after the request.
// One request is worked on at a time; s_axis_tready is high only while the
// controller is idle. Each request gives exactly one result word.
// After accept, a clear or a rejected request goes straight to the loading of
// the result word. A peek first reads the root. An insert reads and compares
// with the parent for each level the key rises, then writes the key. A delete
// reads the root and the last key, takes the last key to the root and sinks it,
// reading and comparing both children for each level. Each heap level takes a
// memory read state and a compare-and-write state of the single-write heap
// memory. The controller returns to idle once the result word is loaded.
// A finished result sits in the output register; the next request is taken
// while it waits, but that request's result is held until m_axis_tready takes
// the earlier word. Reset empties the heap and drops any pending result;
// the heap memory itself is not cleared.
module max_heap_priority_queue #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [hpq_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // mode[1:0], key[33:2]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [hpq_pkg::M_TDATA_W-1:0]     m_axis_tdata   // value, status, occupancy
);

    hpq_pkg::t_dp_cmd    cmd;
    hpq_pkg::t_dp_status st;
    hpq_pkg::t_mode      mode;
    logic signed [hpq_pkg::KEY_W-1:0] key;

    assign mode = hpq_pkg::t_mode'(s_axis_tdata[hpq_pkg::MODE_W-1:0]);
    assign key  = s_axis_tdata[hpq_pkg::MODE_W +: hpq_pkg::KEY_W];

    hpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_mode      (mode),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    hpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_key      (key),
        .o_st       (st),
        .o_out_data (m_axis_tdata)
    );

endmodule

[bench/hpq_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the max-heap priority queue: keeps its own copy of the heap,
// predicts the result word of every accepted request and compares it on the output channel.
// Depends on hpq_pkg for the mode and status codes and the channel widths.
module hpq_result_checker #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [hpq_pkg::S_TDATA_W-1:0] i_s_tdata,   // mode[1:0], key[33:2]
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [hpq_pkg::M_TDATA_W-1:0] i_m_tdata,   // value, status, occupancy
    output int                            o_pending,
    output int                            o_mismatches
);

    typedef struct packed {
        logic [hpq_pkg::OCC_W-1:0] occupancy;
        hpq_pkg::t_status          status;
        logic [hpq_pkg::KEY_W-1:0] value;
    } t_heap_result;

    logic signed [hpq_pkg::KEY_W-1:0] heap_keys [CAPACITY];
    int                               key_count;
    t_heap_result                     awaited_results [$];
    int                               mismatch_count;
    int                               result_index;

    function automatic void swap_keys(input int a, input int b);
        logic signed [hpq_pkg::KEY_W-1:0] tmp;
        tmp          = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = tmp;
    endfunction

    // Applies one request to the heap copy and returns the word it should produce.
    function automatic t_heap_result apply_heap_request(
        input hpq_pkg::t_mode                   mode,
        input logic signed [hpq_pkg::KEY_W-1:0] key
    );
        t_heap_result res;
        int           pos;
        int           up;
        int           best;
        int           lc;
        int           rc;
        bit           done;
        res.value  = '0;
        res.status = hpq_pkg::STATUS_OK;
        case (mode)
            hpq_pkg::MODE_INSERT: begin
                if (key_count >= CAPACITY) begin
                    res.status = hpq_pkg::STATUS_FULL;
                end else begin
                    heap_keys[key_count] = key;
                    pos  = key_count;
                    done = 1'b0;
                    // A key only rises past a strictly smaller parent.
                    while (pos > 0 && !done) begin
                        up = (pos - 1) / 2;
                        if (heap_keys[pos] > heap_keys[up]) begin
                            swap_keys(pos, up);
                            pos = up;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    key_count++;
                end
            end
            hpq_pkg::MODE_DELETE: begin
                if (key_count == 0) begin
                    res.value  = '1;
                    res.status = hpq_pkg::STATUS_EMPTY;
                end else begin
                    res.value = heap_keys[0];
                    key_count--;
                    heap_keys[0] = heap_keys[key_count];
                    pos  = 0;
                    done = 1'b0;
                    // The left child wins a tie, so the right one must be strictly greater.
                    while (!done) begin
                        best = pos;
                        lc   = 2 * pos + 1;
                        rc   = 2 * pos + 2;
                        if (lc < key_count && heap_keys[lc] > heap_keys[best]) best = lc;
                        if (rc < key_count && heap_keys[rc] > heap_keys[best]) best = rc;
                        if (best == pos) begin
                            done = 1'b1;
                        end else begin
                            swap_keys(pos, best);
                            pos = best;
                        end
                    end
                end
            end
            hpq_pkg::MODE_PEEK: begin
                if (key_count == 0) begin
                    res.value  = '1;
                    res.status = hpq_pkg::STATUS_EMPTY;
                end else begin
                    res.value = heap_keys[0];
                end
            end
            default: begin
                key_count = 0;
            end
        endcase
        res.occupancy = key_count[hpq_pkg::OCC_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_heap_result got;
        t_heap_result want;
        if (!i_rst_n) begin
            key_count = 0;
            awaited_results.delete();
        end else begin
            // The output side is checked first: a word accepted at this edge can never
            // belong to a request accepted at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_heap_result)-1:0];
                if (awaited_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result word: value %0d status %0d occ %0d",
                                 $realtime, $signed(got.value), got.status, got.occupancy);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.value !== want.value || got.status !== want.status ||
                        got.occupancy !== want.occupancy) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: result %0d: expected value %0d status %0d occ %0d",
                                     $realtime, result_index, $signed(want.value),
                                     want.status, want.occupancy);
                            $display("%0t: result %0d: got value %0d status %0d occ %0d",
                                     $realtime, result_index, $signed(got.value),
                                     got.status, got.occupancy);
                        end
                        mismatch_count++;
                    end
                end
                result_index++;
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(apply_heap_request(
                    hpq_pkg::t_mode'(i_s_tdata[hpq_pkg::MODE_W-1:0]),
                    i_s_tdata[hpq_pkg::MODE_W +: hpq_pkg::KEY_W]));
        end
        o_pending    <= awaited_results.size();
        o_mismatches <= mismatch_count;
    end

endmodule

[bench/tb_max_heap_priority_queue.sv]
`timescale 1ns / 1ps
// Testbench top for the max-heap priority queue: drives request words with random gaps,
// stalls the result channel and gives the verdict.
// Depends on hpq_pkg, max_heap_priority_queue and hpq_result_checker.
module tb_max_heap_priority_queue;

    localparam int CAPACITY     = hpq_pkg::CAPACITY_DEF;
    localparam int KEY_W        = hpq_pkg::KEY_W;
    localparam int PHASE_ITEMS  = 382;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400_000;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [hpq_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;   // mode[1:0], key[33:2]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [hpq_pkg::M_TDATA_W-1:0] m_axis_tdata;         // value, status, occupancy

    int pending;
    int mismatches;

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_left     = 0;
    bit hold_go       = 1'b0;
    bit hold_seen     = 1'b0;
    int occupancy_est = 0;
    bit filling       = 1'b1;
    int cyc           = 0;

    max_heap_priority_queue #(
        .CAPACITY (CAPACITY)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hpq_result_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus toggles hold_go.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_go != hold_seen) begin
            hold_seen     <= hold_go;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        while (cyc < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offers one request word, with random idle cycles in front, and waits for its acceptance.
    // tvalid stays high after acceptance so that back-to-back words need no second assignment.
    task automatic send_request(input hpq_pkg::t_mode mode, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(hpq_pkg::S_TDATA_W-KEY_W-hpq_pkg::MODE_W){1'b0}}, key, mode};
        do @(posedge i_clk); while (!s_axis_tready);
        case (mode)
            hpq_pkg::MODE_INSERT: if (occupancy_est < CAPACITY) occupancy_est++;
            hpq_pkg::MODE_DELETE: if (occupancy_est > 0) occupancy_est--;
            hpq_pkg::MODE_PEEK:   ;
            default:              occupancy_est = 0;
        endcase
    endtask

    // Stops offering and waits until every predicted result word has been taken.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Small keys give plenty of ties; the rest are extremes or fully random.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0, 1, 2, 3: return KEY_W'($urandom_range(8)) - KEY_W'(4);
            4: begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'hffff_ffff;
                    3:       return 32'h0000_0000;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // The heap is walked up to full and back down to empty, so that both the full
    // rejection and the empty responses turn up regularly.
    function automatic hpq_pkg::t_mode pick_mode();
        int roll;
        roll = $urandom_range(99);
        if (filling) begin
            if (roll < 80) return hpq_pkg::MODE_INSERT;
            if (roll < 90) return hpq_pkg::MODE_DELETE;
            if (roll < 99) return hpq_pkg::MODE_PEEK;
            return hpq_pkg::MODE_CLEAR;
        end
        if (roll < 75) return hpq_pkg::MODE_DELETE;
        if (roll < 87) return hpq_pkg::MODE_INSERT;
        if (roll < 99) return hpq_pkg::MODE_PEEK;
        return hpq_pkg::MODE_CLEAR;
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words: empty responses, extreme keys, ties and clears.
        send_request(hpq_pkg::MODE_PEEK,   '0);
        send_request(hpq_pkg::MODE_DELETE, '0);
        send_request(hpq_pkg::MODE_INSERT, 32'h7fff_ffff);
        send_request(hpq_pkg::MODE_INSERT, 32'h8000_0000);
        send_request(hpq_pkg::MODE_INSERT, 32'hffff_ffff);
        send_request(hpq_pkg::MODE_INSERT, 32'h0000_0000);
        send_request(hpq_pkg::MODE_INSERT, 32'h0000_0001);
        send_request(hpq_pkg::MODE_PEEK,   32'hffff_ffff);
        send_request(hpq_pkg::MODE_INSERT, 32'd5);
        send_request(hpq_pkg::MODE_INSERT, 32'd5);
        send_request(hpq_pkg::MODE_INSERT, 32'd5);
        send_request(hpq_pkg::MODE_INSERT, 32'h7fff_ffff);
        send_request(hpq_pkg::MODE_DELETE, '0);
        send_request(hpq_pkg::MODE_DELETE, '0);
        send_request(hpq_pkg::MODE_DELETE, '0);
        send_request(hpq_pkg::MODE_DELETE, '0);
        send_request(hpq_pkg::MODE_PEEK,   '0);
        send_request(hpq_pkg::MODE_CLEAR,  32'h1234_5678);
        send_request(hpq_pkg::MODE_CLEAR,  '0);
        send_request(hpq_pkg::MODE_DELETE, '0);
        send_request(hpq_pkg::MODE_INSERT, 32'h8000_0000);
        send_request(hpq_pkg::MODE_INSERT, 32'h8000_0000);
        send_request(hpq_pkg::MODE_DELETE, '0);
        send_request(hpq_pkg::MODE_DELETE, '0);
        send_request(hpq_pkg::MODE_DELETE, '0);
        wait_for_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 0;  snk_stall_pct <= 0;  end
                1:       begin src_idle_pct = 46; snk_stall_pct <= 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct <= 46; end
                default: begin src_idle_pct = 16; snk_stall_pct <= 16; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (phase == 0 && i == PHASE_ITEMS / 2)
                    hold_go <= ~hold_go;
                if (filling && occupancy_est == CAPACITY && $urandom_range(3) == 0)
                    filling = 1'b0;
                else if (!filling && occupancy_est == 0 && $urandom_range(2) == 0)
                    filling = 1'b1;
                send_request(pick_mode(), pick_key());
            end
            wait_for_results();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/hpq_pkg.sv
rtl/hpq_ctrl.sv
rtl/hpq_dp.sv
rtl/max_heap_priority_queue.sv
bench/hpq_result_checker.sv
bench/tb_max_heap_priority_queue.sv
